/* rtl/bqf_pkg.sv */
// bqf_pkg: shared constants, register and operand codes, and control
// structs for the biquad filter unit
// no dependencies

package bqf_pkg;

    // width of the two stored feedback nodes
    localparam int DELAY_BITS = 40;

    // configuration register indexes
    localparam int REG_INDEX_BITS = 3;
    localparam logic [REG_INDEX_BITS-1:0] REG_FF_ZERO = 3'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_FF_ONE  = 3'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_FF_TWO  = 3'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_FB_ONE  = 3'd3;
    localparam logic [REG_INDEX_BITS-1:0] REG_FB_TWO  = 3'd4;

    // multiplier operand sources
    localparam logic [1:0] OPND_W1 = 2'd0;
    localparam logic [1:0] OPND_W2 = 2'd1;
    localparam logic [1:0] OPND_W  = 2'd2;

    // sequencer step count
    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] LAST_STEP = 4'd11;

    // control for one multiply-accumulate issue
    typedef struct packed {
        logic issue;
        logic first;
        logic hi;
    } mac_ctrl_t;

    // control from the sequencer to the datapath
    typedef struct packed {
        mac_ctrl_t                 mac;
        logic [REG_INDEX_BITS-1:0] coef_sel;
        logic [1:0]                opnd_sel;
        logic                      w_load;
        logic                      out_load;
    } seq_ctrl_t;

endpackage

/* rtl/biquad_iir_filter_unit.sv */
// biquad_iir_filter_unit: top level of the direct-form-II biquad, holding
// coefficients, delays, node and output rounding, and the result register
// depends on bqf_pkg, bqf_mac, bqf_seq

// Each accepted sample is worked through by the sequencer: five coefficient
// products are formed on one shared multiply-accumulate unit, each split into
// an upper and a lower half of the 40-bit delay operand, so ten issues pass
// through the product register and the accumulator before the output is
// rounded and registered in the last step. The input is not ready during the
// run and opens again once the result is loaded, so a new sample is not taken
// until the previous one is worked through. A finished result sits in an
// output register, so the next sample is taken while it waits. If a result is
// still unread when the following one completes, the unit holds until it is
// read. Coefficient requests are taken only while the unit is idle and apply
// from the next sample on; indexes outside the five registers are ignored.

module biquad_iir_filter_unit #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [SAMPLE_BITS-1:0]         sample_out,
    output logic                                  clipped,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bqf_pkg::REG_INDEX_BITS-1:0]    cfg_index,
    input  logic signed [COEF_FRAC_BITS+1:0]      cfg_data
);

    localparam int DB = bqf_pkg::DELAY_BITS;
    localparam int SB = SAMPLE_BITS;
    localparam int F  = COEF_FRAC_BITS;
    localparam int CW = F + 2;
    localparam int HB = DB / 2;
    localparam int OW = HB + 1;
    localparam int AW = CW + DB + 2;
    localparam int XW = SB + F;
    localparam int FW = AW - F;
    localparam int WW = ((XW > FW) ? XW : FW) + 1;
    localparam int YW = AW - 2 * F;
    localparam int YX = (YW > SB) ? YW : SB;

    localparam logic signed [AW-1:0] W_ROUND = AW'(1) <<< (F - 1);
    localparam logic signed [AW-1:0] Y_ROUND = AW'(1) <<< (2 * F - 1);
    localparam logic signed [CW-1:0] UNITY   = CW'(1) <<< F;

    logic signed [CW-1:0] ff_gain_zero_reg;
    logic signed [CW-1:0] ff_gain_one_reg;
    logic signed [CW-1:0] ff_gain_two_reg;
    logic signed [CW-1:0] fb_gain_one_reg;
    logic signed [CW-1:0] fb_gain_two_reg;

    logic signed [DB-1:0] delay_first_reg;
    logic signed [DB-1:0] delay_second_reg;
    logic signed [DB-1:0] w_reg;
    logic signed [DB-1:0] w_next;
    logic                 hit_w_reg;
    logic                 hit_w_next;
    logic signed [SB-1:0] x_reg;

    logic                 out_valid_reg;
    logic signed [SB-1:0] sample_out_reg;
    logic signed [SB-1:0] sample_out_next;
    logic                 clipped_reg;
    logic                 clipped_next;

    logic                 busy;
    logic                 out_free;
    bqf_pkg::seq_ctrl_t   ctrl;

    logic signed [CW-1:0] coef;
    logic signed [DB-1:0] opnd_full;
    logic signed [OW-1:0] opnd;
    logic signed [AW-1:0] acc;

    logic signed [AW-1:0] acc_w_rnd;
    logic signed [FW-1:0] fb_q;
    logic signed [WW-1:0] w_raw;
    logic                 w_fits;

    logic signed [AW-1:0] acc_y_rnd;
    logic signed [YW-1:0] y_q;
    logic signed [YX-1:0] y_ext;
    logic                 y_fits;

    // handshakes
    assign in_ready  = !busy;
    assign cfg_ready = !busy;
    assign out_free  = !out_valid_reg || out_ready;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_gain_zero_reg <= UNITY;
            ff_gain_one_reg  <= '0;
            ff_gain_two_reg  <= '0;
            fb_gain_one_reg  <= '0;
            fb_gain_two_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bqf_pkg::REG_FF_ZERO: ff_gain_zero_reg <= cfg_data;
                bqf_pkg::REG_FF_ONE:  ff_gain_one_reg  <= cfg_data;
                bqf_pkg::REG_FF_TWO:  ff_gain_two_reg  <= cfg_data;
                bqf_pkg::REG_FB_ONE:  fb_gain_one_reg  <= cfg_data;
                bqf_pkg::REG_FB_TWO:  fb_gain_two_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // sample capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg <= sample_in;
        end
    end

    bqf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_valid),
        .out_free (out_free),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    // coefficient select
    always_comb
    begin
        case (ctrl.coef_sel)
            bqf_pkg::REG_FF_ZERO: coef = ff_gain_zero_reg;
            bqf_pkg::REG_FF_ONE:  coef = ff_gain_one_reg;
            bqf_pkg::REG_FF_TWO:  coef = ff_gain_two_reg;
            bqf_pkg::REG_FB_ONE:  coef = fb_gain_one_reg;
            bqf_pkg::REG_FB_TWO:  coef = fb_gain_two_reg;
            default:              coef = ff_gain_zero_reg;
        endcase
    end

    // operand select and half split
    always_comb
    begin
        case (ctrl.opnd_sel)
            bqf_pkg::OPND_W1: opnd_full = delay_first_reg;
            bqf_pkg::OPND_W2: opnd_full = delay_second_reg;
            bqf_pkg::OPND_W:  opnd_full = w_reg;
            default:          opnd_full = delay_first_reg;
        endcase
    end

    assign opnd = ctrl.mac.hi ? OW'(signed'(opnd_full[DB-1:HB]))
                              : signed'({1'b0, opnd_full[HB-1:0]});

    bqf_mac #(
        .CW    (CW),
        .OW    (OW),
        .AW    (AW),
        .SHIFT (HB)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl.mac),
        .coef  (coef),
        .opnd  (opnd),
        .acc   (acc)
    );

    // feedback node: x scaled minus rounded feedback sum, clamped
    assign acc_w_rnd = acc + W_ROUND;
    assign fb_q      = acc_w_rnd[AW-1:F];
    assign w_raw     = WW'(signed'({x_reg, {F{1'b0}}})) - WW'(fb_q);
    assign w_fits    = (&w_raw[WW-1:DB-1]) || !(|w_raw[WW-1:DB-1]);

    always_comb
    begin
        hit_w_next = !w_fits;
        if (w_fits)
        begin
            w_next = w_raw[DB-1:0];
        end
        else if (w_raw[WW-1])
        begin
            w_next = {1'b1, {(DB-1){1'b0}}};
        end
        else
        begin
            w_next = {1'b0, {(DB-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.w_load)
        begin
            w_reg     <= w_next;
            hit_w_reg <= hit_w_next;
        end
    end

    // output: rounded feed-forward sum, clamped
    assign acc_y_rnd = acc + Y_ROUND;
    assign y_q       = acc_y_rnd[AW-1:2*F];
    assign y_ext     = YX'(y_q);
    assign y_fits    = (&y_ext[YX-1:SB-1]) || !(|y_ext[YX-1:SB-1]);

    always_comb
    begin
        clipped_next = hit_w_reg || !y_fits;
        if (y_fits)
        begin
            sample_out_next = y_ext[SB-1:0];
        end
        else if (y_ext[YX-1])
        begin
            sample_out_next = {1'b1, {(SB-1){1'b0}}};
        end
        else
        begin
            sample_out_next = {1'b0, {(SB-1){1'b1}}};
        end
    end

    // delay line shift at the end of each sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_first_reg  <= '0;
            delay_second_reg <= '0;
        end
        else if (ctrl.out_load)
        begin
            delay_second_reg <= delay_first_reg;
            delay_first_reg  <= w_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            sample_out_reg <= sample_out_next;
            clipped_reg    <= clipped_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

`ifndef SYNTHESIS
    // a request starts a run, so the input closes the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still ready after a request was taken");

    // a result only appears at the end of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(busy))
        else $error("result appeared without a run");

    // delays hold while idle, so configuration cannot disturb them
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> ($stable(delay_first_reg) && $stable(delay_second_reg)))
        else $error("delay changed while idle");
`endif

endmodule

/* rtl/bqf_mac.sv */
// bqf_mac: shared multiply-accumulate unit, registered product then
// accumulator, upper operand halves weighted by a shift
// depends on bqf_pkg

module bqf_mac #(
    parameter int CW    = 18,
    parameter int OW    = 21,
    parameter int AW    = 60,
    parameter int SHIFT = 20
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bqf_pkg::mac_ctrl_t      ctrl,
    input  logic signed [CW-1:0]    coef,
    input  logic signed [OW-1:0]    opnd,
    output logic signed [AW-1:0]    acc
);

    localparam int PW = CW + OW;

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    bqf_pkg::mac_ctrl_t   ctrl_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] term;

    // multiplier stage
    assign prod_next = coef * opnd;

    // control follows the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // weight the product and accumulate
    assign term = ctrl_reg.hi ? (AW'(prod_reg) <<< SHIFT) : AW'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl_reg.issue)
        begin
            if (ctrl_reg.first)
            begin
                acc_next = term;
            end
            else
            begin
                acc_next = acc_reg + term;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

/* rtl/bqf_seq.sv */
// bqf_seq: step sequencer driving the shared multiply-accumulate unit
// over the feedback sum, the output sum and the result hand-off
// depends on bqf_pkg

module bqf_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                out_free,
    output logic                busy,
    output bqf_pkg::seq_ctrl_t  ctrl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                          state_reg;
    logic                          state_next;
    logic [bqf_pkg::STEP_BITS-1:0] step_reg;
    logic [bqf_pkg::STEP_BITS-1:0] step_next;
    logic                          at_last;

    assign at_last = (step_reg == bqf_pkg::LAST_STEP);

    // state and step counter
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (at_last)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign busy = (state_reg == ST_RUN);

    // step decode: feedback products, then feed-forward products
    always_comb
    begin
        ctrl = '0;
        case (step_reg)
            4'd0:
            begin
                ctrl.mac      = '{issue: 1'b1, first: 1'b1, hi: 1'b1};
                ctrl.coef_sel = bqf_pkg::REG_FB_ONE;
                ctrl.opnd_sel = bqf_pkg::OPND_W1;
            end
            4'd1:
            begin
                ctrl.mac      = '{issue: 1'b1, first: 1'b0, hi: 1'b0};
                ctrl.coef_sel = bqf_pkg::REG_FB_ONE;
                ctrl.opnd_sel = bqf_pkg::OPND_W1;
            end
            4'd2:
            begin
                ctrl.mac      = '{issue: 1'b1, first: 1'b0, hi: 1'b1};
                ctrl.coef_sel = bqf_pkg::REG_FB_TWO;
                ctrl.opnd_sel = bqf_pkg::OPND_W2;
            end
            4'd3:
            begin
                ctrl.mac      = '{issue: 1'b1, first: 1'b0, hi: 1'b0};
                ctrl.coef_sel = bqf_pkg::REG_FB_TWO;
                ctrl.opnd_sel = bqf_pkg::OPND_W2;
            end
            4'd4:
            begin
                ctrl.mac      = '{issue: 1'b1, first: 1'b1, hi: 1'b1};
                ctrl.coef_sel = bqf_pkg::REG_FF_ONE;
                ctrl.opnd_sel = bqf_pkg::OPND_W1;
            end
            4'd5:
            begin
                // feedback sum is complete in the accumulator here
                ctrl.mac      = '{issue: 1'b1, first: 1'b0, hi: 1'b0};
                ctrl.coef_sel = bqf_pkg::REG_FF_ONE;
                ctrl.opnd_sel = bqf_pkg::OPND_W1;
                ctrl.w_load   = 1'b1;
            end
            4'd6:
            begin
                ctrl.mac      = '{issue: 1'b1, first: 1'b0, hi: 1'b1};
                ctrl.coef_sel = bqf_pkg::REG_FF_TWO;
                ctrl.opnd_sel = bqf_pkg::OPND_W2;
            end
            4'd7:
            begin
                ctrl.mac      = '{issue: 1'b1, first: 1'b0, hi: 1'b0};
                ctrl.coef_sel = bqf_pkg::REG_FF_TWO;
                ctrl.opnd_sel = bqf_pkg::OPND_W2;
            end
            4'd8:
            begin
                ctrl.mac      = '{issue: 1'b1, first: 1'b0, hi: 1'b1};
                ctrl.coef_sel = bqf_pkg::REG_FF_ZERO;
                ctrl.opnd_sel = bqf_pkg::OPND_W;
            end
            4'd9:
            begin
                ctrl.mac      = '{issue: 1'b1, first: 1'b0, hi: 1'b0};
                ctrl.coef_sel = bqf_pkg::REG_FF_ZERO;
                ctrl.opnd_sel = bqf_pkg::OPND_W;
            end
            bqf_pkg::LAST_STEP:
            begin
                ctrl.out_load = busy && out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
        if (!busy)
        begin
            ctrl = '0;
        end
    end

endmodule

/* verif/biquad_iir_filter_unit_tb.sv */
// biquad_iir_filter_unit_tb: self-checking bench for the direct-form-II biquad,
// a directed table, then random coefficient phases checked by a bit-exact predictor
// depends on bqf_pkg and biquad_iir_filter_unit

module biquad_iir_filter_unit_tb;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
    localparam int INDEX_BITS     = bqf_pkg::REG_INDEX_BITS;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = 18'sh1FFFF;
    localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = 18'sh20000;
    localparam logic signed [COEF_BITS-1:0]   COEF_UNITY = 18'sd65536;
    localparam logic signed [COEF_BITS-1:0]   COEF_HALF  = 18'sd32768;

    // indexes past the five coefficient registers
    localparam logic [INDEX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [INDEX_BITS-1:0] REG_SPARE_LAST  = 3'd7;

    localparam longint DELAY_MAX = (64'sd1 <<< (bqf_pkg::DELAY_BITS - 1)) - 64'sd1;
    localparam longint DELAY_MIN = -DELAY_MAX - 64'sd1;
    localparam longint OUT_MAX   = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint OUT_MIN   = -OUT_MAX - 64'sd1;
    localparam longint NODE_HALF = 64'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam longint OUT_HALF  = 64'sd1 <<< (2 * COEF_FRAC_BITS - 1);

    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_SAMPLES  = 62;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 40;

    typedef enum logic [1:0] {ROW_COEF, ROW_SAMPLE, ROW_TYPED} row_kind_t;
    typedef enum logic [1:0] {COEF_STABLE, COEF_RANDOM, COEF_EXTREME} coef_plan_t;

    typedef struct {
        row_kind_t                      kind;
        logic [INDEX_BITS-1:0]          index;
        logic signed [COEF_BITS-1:0]    coef;
        logic signed [SAMPLE_BITS-1:0]  x;
        logic signed [SAMPLE_BITS-1:0]  level;
        logic                           clip;
    } stim_row_t;

    typedef struct {
        int                             tag;
        logic signed [SAMPLE_BITS-1:0]  level;
        logic                           clip;
    } filtered_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic signed [SAMPLE_BITS-1:0]   sample_in = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0]   sample_out;
    logic                            clipped;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [INDEX_BITS-1:0]           cfg_index = '0;
    logic signed [COEF_BITS-1:0]     cfg_data  = '0;

    // predictor state: coefficients and the two stored nodes
    longint    coef_reg [0:4];
    longint    delay_w1;
    longint    delay_w2;

    filtered_t pending_outputs [$];
    stim_row_t directed_rows [$];
    int        mismatch_count = 0;
    int        samples_taken  = 0;
    int        hold_requests  = 0;

    biquad_iir_filter_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .clipped    (clipped),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    // one filter step: feedback node, output sum, rounding and clamping
    function automatic void filter_sample(input logic signed [SAMPLE_BITS-1:0] x,
                                          output logic signed [SAMPLE_BITS-1:0] level,
                                          output logic clip);
        longint feedback;
        longint node;
        longint acc;
        longint y;
        clip = 1'b0;
        feedback = coef_reg[bqf_pkg::REG_FB_ONE] * delay_w1
                 + coef_reg[bqf_pkg::REG_FB_TWO] * delay_w2;
        node = (longint'(x) <<< COEF_FRAC_BITS)
             - ((feedback + NODE_HALF) >>> COEF_FRAC_BITS);
        if (node > DELAY_MAX)
        begin
            node = DELAY_MAX;
            clip = 1'b1;
        end
        else if (node < DELAY_MIN)
        begin
            node = DELAY_MIN;
            clip = 1'b1;
        end
        acc = coef_reg[bqf_pkg::REG_FF_ZERO] * node
            + coef_reg[bqf_pkg::REG_FF_ONE] * delay_w1
            + coef_reg[bqf_pkg::REG_FF_TWO] * delay_w2;
        y = (acc + OUT_HALF) >>> (2 * COEF_FRAC_BITS);
        if (y > OUT_MAX)
        begin
            y = OUT_MAX;
            clip = 1'b1;
        end
        else if (y < OUT_MIN)
        begin
            y = OUT_MIN;
            clip = 1'b1;
        end
        delay_w2 = delay_w1;
        delay_w1 = node;
        level = y[SAMPLE_BITS-1:0];
    endfunction

    // table rows
    function automatic stim_row_t coef_row(input logic [INDEX_BITS-1:0] index,
                                           input logic signed [COEF_BITS-1:0] value);
        stim_row_t r;
        r = '{ROW_COEF, index, value, '0, '0, 1'b0};
        return r;
    endfunction

    function automatic stim_row_t sample_row(input logic signed [SAMPLE_BITS-1:0] x);
        stim_row_t r;
        r = '{ROW_SAMPLE, '0, '0, x, '0, 1'b0};
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic signed [SAMPLE_BITS-1:0] x,
                                            input logic signed [SAMPLE_BITS-1:0] level,
                                            input logic clip);
        stim_row_t r;
        r = '{ROW_TYPED, '0, '0, x, level, clip};
        return r;
    endfunction

    // random sample: mostly full range, some small values and extremes
    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return ($urandom_range(1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
        else if (pick <= 2)
            return SAMPLE_BITS'($signed($urandom_range(510)) - 255);
        return SAMPLE_BITS'($urandom);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    // drive one sample request, hold it until taken, then log its expected result
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x,
                               input logic typed,
                               input logic signed [SAMPLE_BITS-1:0] typed_level,
                               input logic typed_clip);
        filtered_t r;
        @(negedge clk);
        in_valid  <= 1'b1;
        sample_in <= x;
        do
            @(posedge clk);
        while (!in_ready);
        r.tag = samples_taken;
        filter_sample(x, r.level, r.clip);
        if (typed)
        begin
            r.level = typed_level;
            r.clip  = typed_clip;
        end
        pending_outputs.push_back(r);
        samples_taken++;
    endtask

    task automatic hold_off_input(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // stop sending and wait until every expected result has been read
    task automatic drain_outputs();
        hold_off_input(1);
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // coefficient write request, mirrored into the predictor when taken
    task automatic write_coef(input logic [INDEX_BITS-1:0] index,
                              input logic signed [COEF_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index <= bqf_pkg::REG_FB_TWO)
            coef_reg[index] = longint'(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: stall rate changes every so often, long hold-off on request
    initial
    begin : receiver_pattern
        int hold_left;
        int stall_pct;
        int mode_left;
        int holds_served;
        hold_left    = 0;
        stall_pct    = 0;
        mode_left    = 0;
        holds_served = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                case ($urandom_range(4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 20;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                mode_left = $urandom_range(200, 20);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare each result read with the oldest expectation
    always @(posedge clk)
    begin : check_results
        filtered_t expected;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outputs.size() == 0)
                report_mismatch($sformatf("result %0d with nothing expected", sample_out));
            else
            begin
                expected = pending_outputs.pop_front();
                if (sample_out !== expected.level)
                    report_mismatch($sformatf("sample %0d: sample_out %0d, expected %0d",
                                              expected.tag, sample_out, expected.level));
                if (clipped !== expected.clip)
                    report_mismatch($sformatf("sample %0d: clipped %0b, expected %0b",
                                              expected.tag, clipped, expected.clip));
            end
        end
    end

    // watchdog on cycles with no request taken on any channel
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("biquad_iir_filter_unit_tb: FAIL");
        $finish;
    end

    // stimulus: reset, directed table, then random coefficient phases
    initial
    begin : stimulus
        int         sent;
        int         burst;
        int         k;
        int         fb_two;
        int         margin;
        bit         gapless;
        coef_plan_t plan;

        coef_reg = '{longint'(COEF_UNITY), 0, 0, 0, 0};
        delay_w1 = 0;
        delay_w2 = 0;

        // pass-through after reset, rounding at one half, output clamping
        directed_rows.push_back(typed_row(24'sd0, 24'sd0, 1'b0));
        directed_rows.push_back(typed_row(SAMPLE_MAX, SAMPLE_MAX, 1'b0));
        directed_rows.push_back(typed_row(SAMPLE_MIN, SAMPLE_MIN, 1'b0));
        directed_rows.push_back(typed_row(24'sd1, 24'sd1, 1'b0));
        directed_rows.push_back(typed_row(-24'sd1, -24'sd1, 1'b0));
        directed_rows.push_back(coef_row(bqf_pkg::REG_FF_ZERO, COEF_HALF));
        directed_rows.push_back(typed_row(24'sd1, 24'sd1, 1'b0));
        directed_rows.push_back(typed_row(-24'sd1, 24'sd0, 1'b0));
        directed_rows.push_back(coef_row(bqf_pkg::REG_FF_ZERO, COEF_MAX));
        directed_rows.push_back(typed_row(SAMPLE_MAX, SAMPLE_MAX, 1'b1));
        directed_rows.push_back(typed_row(SAMPLE_MIN, SAMPLE_MIN, 1'b1));
        directed_rows.push_back(coef_row(bqf_pkg::REG_FF_ZERO, COEF_MIN));
        directed_rows.push_back(typed_row(SAMPLE_MIN, SAMPLE_MAX, 1'b1));
        directed_rows.push_back(typed_row(SAMPLE_MAX, SAMPLE_MIN, 1'b1));
        // strong feedback drives the stored node into saturation
        directed_rows.push_back(coef_row(bqf_pkg::REG_FF_ZERO, COEF_UNITY));
        directed_rows.push_back(coef_row(bqf_pkg::REG_FB_ONE, COEF_MIN));
        directed_rows.push_back(sample_row(SAMPLE_MAX));
        directed_rows.push_back(sample_row(SAMPLE_MAX));
        directed_rows.push_back(sample_row(SAMPLE_MIN));
        directed_rows.push_back(coef_row(bqf_pkg::REG_FB_TWO, COEF_MAX));
        directed_rows.push_back(coef_row(bqf_pkg::REG_FF_ONE, COEF_MIN));
        directed_rows.push_back(coef_row(bqf_pkg::REG_FF_TWO, COEF_MAX));
        directed_rows.push_back(sample_row(SAMPLE_MIN));
        directed_rows.push_back(sample_row(SAMPLE_MAX));
        // writes to spare indexes must leave the coefficients alone
        directed_rows.push_back(coef_row(REG_SPARE_FIRST, 18'sd12345));
        directed_rows.push_back(coef_row(REG_SPARE_LAST, -18'sd1));
        directed_rows.push_back(sample_row(24'sd12345));
        directed_rows.push_back(sample_row(-24'sd42));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_COEF:
                begin
                    drain_outputs();
                    write_coef(directed_rows[i].index, directed_rows[i].coef);
                end
                ROW_SAMPLE:
                    send_sample(directed_rows[i].x, 1'b0, '0, 1'b0);
                default:
                    send_sample(directed_rows[i].x, 1'b1, directed_rows[i].level,
                                directed_rows[i].clip);
            endcase
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_outputs();
            plan = coef_plan_t'(phase % 3);
            case (plan)
                // stable second-order section with random zeros
                COEF_STABLE:
                begin
                    fb_two = $signed($urandom_range(120000)) - 60000;
                    margin = 65536 + fb_two - 2000;
                    write_coef(bqf_pkg::REG_FB_TWO, COEF_BITS'(fb_two));
                    write_coef(bqf_pkg::REG_FB_ONE,
                               COEF_BITS'($signed($urandom_range(2 * margin)) - margin));
                    write_coef(bqf_pkg::REG_FF_ZERO,
                               COEF_BITS'($signed($urandom_range(80000)) - 40000));
                    write_coef(bqf_pkg::REG_FF_ONE,
                               COEF_BITS'($signed($urandom_range(80000)) - 40000));
                    write_coef(bqf_pkg::REG_FF_TWO,
                               COEF_BITS'($signed($urandom_range(80000)) - 40000));
                end
                COEF_RANDOM:
                begin
                    for (int r = bqf_pkg::REG_FF_ZERO; r <= bqf_pkg::REG_FB_TWO; r++)
                        if ($urandom_range(1) != 0)
                            write_coef(INDEX_BITS'(r), COEF_BITS'($urandom));
                    if ($urandom_range(3) == 0)
                        write_coef(INDEX_BITS'($urandom_range(REG_SPARE_LAST,
                                                               REG_SPARE_FIRST)),
                                   COEF_BITS'($urandom));
                end
                default:
                begin
                    for (int r = bqf_pkg::REG_FF_ZERO; r <= bqf_pkg::REG_FB_TWO; r++)
                        case ($urandom_range(3))
                            0:       write_coef(INDEX_BITS'(r), COEF_MIN);
                            1:       write_coef(INDEX_BITS'(r), COEF_MAX);
                            2:       write_coef(INDEX_BITS'(r), '0);
                            default: write_coef(INDEX_BITS'(r), COEF_UNITY);
                        endcase
                end
            endcase

            // one phase runs against a long receiver hold-off with no input gaps
            if (phase == 4)
                hold_requests++;
            gapless = (phase == 4) || ($urandom_range(3) == 0);

            sent = 0;
            while (sent < PHASE_SAMPLES)
            begin
                burst = gapless ? PHASE_SAMPLES : $urandom_range(24, 1);
                for (k = 0; k < burst && sent < PHASE_SAMPLES; k++)
                begin
                    send_sample(random_sample(), 1'b0, '0, 1'b0);
                    sent++;
                end
                if (!gapless)
                    hold_off_input($urandom_range(16));
            end
        end

        drain_outputs();
        if (mismatch_count == 0)
            $display("biquad_iir_filter_unit_tb: PASS");
        else
            $display("biquad_iir_filter_unit_tb: FAIL");
        $finish;
    end

endmodule
